/* sv/pdwq_pkg.sv */
package pdwq_pkg;

  // fixed field widths of the stream payload
  localparam int ID_W  = 5;
  localparam int PRI_W = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // command codes carried on in_tuser
  localparam logic CMD_QUEUE  = 1'b0;
  localparam logic CMD_RETIRE = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_READ,
    ST_EMIT
  } pdwq_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic enq;   // apply the accepted queue beat
    logic seek;  // select the highest nonempty bucket and load its head
    logic emit;  // send the current id and step along the list
  } pdwq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic has_work;     // some bucket still holds ids
    logic out_free;     // output register can take a beat this cycle
    logic cur_is_tail;  // current id closes its bucket
  } pdwq_stat_t;

endpackage

/* sv/pdwq_ram.sv */
module pdwq_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/pdwq_ctrl.sv */
module pdwq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tuser,
  output logic                   in_tready,
  input  pdwq_pkg::pdwq_stat_t   stat,
  output pdwq_pkg::pdwq_cmd_t    cmd
);

  pdwq_pkg::pdwq_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdwq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      pdwq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == pdwq_pkg::CMD_QUEUE) begin
            cmd.enq = 1'b1;
          end else begin
            state_nxt = pdwq_pkg::ST_SEEK;
          end
        end
      end
      pdwq_pkg::ST_SEEK: begin
        if (stat.has_work) begin
          cmd.seek  = 1'b1;
          state_nxt = pdwq_pkg::ST_READ;
        end else begin
          state_nxt = pdwq_pkg::ST_IDLE;
        end
      end
      // link memory read of the current id is in flight
      pdwq_pkg::ST_READ: begin
        state_nxt = pdwq_pkg::ST_EMIT;
      end
      pdwq_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.cur_is_tail ? pdwq_pkg::ST_SEEK : pdwq_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = pdwq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/pdwq_dp.sv */
module pdwq_dp #(
  parameter int NUM_BUCKETS = 8,
  parameter int NUM_IDS     = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [pdwq_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  pdwq_pkg::pdwq_cmd_t                   cmd,
  output pdwq_pkg::pdwq_stat_t                  stat,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pdwq_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tlast
);

  localparam int IW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  // input fields
  logic [pdwq_pkg::ID_W-1:0]         work_id;
  logic signed [pdwq_pkg::PRI_W-1:0] priority_req;
  logic [6:0]                        id_ext;
  logic [IW-1:0]                     in_id;
  logic                              id_ok;
  logic [BW-1:0]                     in_b;

  // state
  logic [NUM_IDS-1:0]     marks_r;
  logic [NUM_BUCKETS-1:0] nonempty_r;
  logic [IW-1:0]          head_r [NUM_BUCKETS];
  logic [IW-1:0]          tail_r [NUM_BUCKETS];
  logic [IW-1:0]          cur_r;
  logic [BW-1:0]          cb_r;
  logic                   out_valid_r;
  logic [pdwq_pkg::ID_W-1:0] out_id_r;
  logic                   out_last_r;

  // derived
  logic [BW-1:0]          top_b;
  logic [IW-1:0]          tail_rd;
  logic [IW-1:0]          walk_tail;
  logic                   fresh;
  logic                   lower_any;
  logic [NUM_BUCKETS-1:0] lower_mask;
  logic                   ram_we;
  logic [IW-1:0]          link_rd;
  logic [6:0]             cur_ext;

  assign work_id      = in_tdata[4:0];
  assign priority_req = in_tdata[12:5];

  // id range check and index
  assign id_ext = {2'b00, work_id};
  assign id_ok  = id_ext < 7'(NUM_IDS);
  assign in_id  = id_ext[IW-1:0];

  // clamp priority into the bucket range
  always_comb begin
    if (priority_req[pdwq_pkg::PRI_W-1]) begin
      in_b = '0;
    end else if ({1'b0, priority_req[6:0]} >= 8'(NUM_BUCKETS)) begin
      in_b = BW'(NUM_BUCKETS - 1);
    end else begin
      in_b = priority_req[BW-1:0];
    end
  end

  // highest nonempty bucket
  always_comb begin
    top_b = '0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (nonempty_r[i]) begin
        top_b = BW'(i);
      end
    end
  end

  // tail lookups: queued bucket for linking, walked bucket for the end test
  assign tail_rd   = tail_r[in_b];
  assign walk_tail = tail_r[cb_r];

  assign fresh  = cmd.enq && id_ok && !marks_r[in_id];
  assign ram_we = fresh && nonempty_r[in_b];

  // any bucket below the current one still pending
  assign lower_mask = (NUM_BUCKETS'(1) << cb_r) - NUM_BUCKETS'(1);
  assign lower_any  = |(nonempty_r & lower_mask);

  assign stat.has_work    = |nonempty_r;
  assign stat.out_free    = !out_valid_r || out_tready;
  assign stat.cur_is_tail = (cur_r == walk_tail);

  // link memory: written at the old tail, read at the current id
  pdwq_ram #(
    .WIDTH (IW),
    .DEPTH (NUM_IDS)
  ) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_rd),
    .wdata (in_id),
    .raddr (cur_r),
    .rdata (link_rd)
  );

  // queued marks and nonempty bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r    <= '0;
      nonempty_r <= '0;
    end else begin
      if (fresh) begin
        marks_r[in_id]    <= 1'b1;
        nonempty_r[in_b]  <= 1'b1;
      end
      if (cmd.emit) begin
        marks_r[cur_r] <= 1'b0;
        if (stat.cur_is_tail) begin
          nonempty_r[cb_r] <= 1'b0;
        end
      end
    end
  end

  // bucket head and tail
  always_ff @(posedge clk) begin
    if (fresh) begin
      tail_r[in_b] <= in_id;
      if (!nonempty_r[in_b]) begin
        head_r[in_b] <= in_id;
      end
    end
  end

  // walk position
  always_ff @(posedge clk) begin
    if (cmd.seek) begin
      cb_r  <= top_b;
      cur_r <= head_r[top_b];
    end else if (cmd.emit && !stat.cur_is_tail) begin
      cur_r <= link_rd;
    end
  end

  // output register
  assign cur_ext = 7'(cur_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_id_r   <= cur_ext[4:0];
      out_last_r <= stat.cur_is_tail && !lower_any;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_id_r};
  assign out_tlast  = out_last_r;

endmodule

/* sv/priority_deferred_work_queue.sv */
// Deferred work queue with duplicate suppression and priority buckets. A
// queue beat (in_tuser = 0) is applied when accepted: the priority is clamped to
// 0..NUM_BUCKETS-1, and the work id is appended to that bucket's list unless
// it is already pending or not below NUM_IDS. A retire beat (in_tuser = 1)
// sends every pending id, highest bucket first and in arrival order within a
// bucket, with out_tlast on the final one; a retire with nothing pending sends
// nothing. A retire is accepted in IDLE, then passes SEEK per nonempty bucket
// and once more to find none left, and READ then EMIT per id, READ covering the
// registered link memory read; EMIT waits while out_tready is low and the
// output is full. No new beat is taken until the run is walked, but the last
// result may still sit in the output register. No clearing pass follows reset.
module priority_deferred_work_queue #(
  parameter int NUM_BUCKETS = 8,
  parameter int NUM_IDS     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // work_id [4:0], priority_req [12:5], zero
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_id [4:0], zero
  output logic        out_tlast
);

  pdwq_pkg::pdwq_cmd_t  cmd;
  pdwq_pkg::pdwq_stat_t stat;

  // sequencer
  pdwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // lists, marks and output register
  pdwq_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .NUM_IDS     (NUM_IDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* sim/tb_priority_deferred_work_queue.sv */
`timescale 1ns / 100ps

module tb_priority_deferred_work_queue;

  localparam int BUCKETS        = 8;
  localparam int IDS            = 32;
  localparam int RANDOM_ITEMS   = 500;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic                              cmd;
    logic [pdwq_pkg::ID_W-1:0]         id;
    logic signed [pdwq_pkg::PRI_W-1:0] pri;
  } work_beat_t;

  typedef struct {
    logic [pdwq_pkg::ID_W-1:0] id;
    logic                      last;
  } dispatch_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  // work_id [4:0], priority_req [12:5], zero
  logic [pdwq_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0; // cmd
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [pdwq_pkg::OUT_TDATA_W-1:0] out_tdata;       // out_id [4:0], zero
  logic                             out_tlast;

  // pending beats for the driver and dispatches still owed by the block
  work_beat_t work_beats[$];
  dispatch_t  owed_dispatch[$];
  int         fail_count = 0;

  // shadow of the queue state
  logic                      pend_mark [IDS];
  logic [pdwq_pkg::ID_W-1:0] link_next [IDS];
  logic [pdwq_pkg::ID_W-1:0] list_head [BUCKETS];
  logic [pdwq_pkg::ID_W-1:0] list_tail [BUCKETS];
  logic                      list_used [BUCKETS];

  priority_deferred_work_queue #(
    .NUM_BUCKETS(BUCKETS),
    .NUM_IDS    (IDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  // clamp a signed priority into the bucket range
  function automatic int bucket_for(logic signed [pdwq_pkg::PRI_W-1:0] pri);
    if (pri < 0) return 0;
    if (pri >= BUCKETS) return BUCKETS - 1;
    return int'(pri);
  endfunction

  // update the shadow state for one accepted beat, owing any dispatches
  task automatic track_work_beat(logic cmd, logic [pdwq_pkg::ID_W-1:0] id,
                                 logic signed [pdwq_pkg::PRI_W-1:0] pri);
    int        b;
    int        steps;
    int        first_new;
    logic [pdwq_pkg::ID_W-1:0] cur;
    dispatch_t d;
    first_new = owed_dispatch.size();
    if (cmd == pdwq_pkg::CMD_QUEUE) begin
      b = bucket_for(pri);
      if (id < IDS && !pend_mark[id]) begin
        pend_mark[id] = 1'b1;
        if (list_used[b]) begin
          link_next[list_tail[b]] = id;
        end else begin
          list_head[b] = id;
          list_used[b] = 1'b1;
        end
        list_tail[b] = id;
      end
    end else begin
      for (b = BUCKETS - 1; b >= 0; b--) begin
        if (list_used[b]) begin
          cur = list_head[b];
          steps = 0;
          while (steps < IDS) begin
            pend_mark[cur] = 1'b0;
            d.id = cur;
            d.last = 1'b0;
            owed_dispatch.push_back(d);
            steps++;
            if (cur == list_tail[b]) break;
            cur = link_next[cur];
          end
          list_used[b] = 1'b0;
        end
      end
      if (owed_dispatch.size() > first_new)
        owed_dispatch[owed_dispatch.size() - 1].last = 1'b1;
    end
  endtask

  task automatic add_beat(logic cmd, int id, int pri);
    work_beat_t w;
    w.cmd = cmd;
    w.id = id[pdwq_pkg::ID_W-1:0];
    w.pri = pri[pdwq_pkg::PRI_W-1:0];
    work_beats.push_back(w);
  endtask

  // sender: bursts of beats with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) work_beats.delete(0);
      if (in_tvalid && !in_tready) begin
        // hold the current beat
      end else if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left--;
      end else if (work_beats.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= work_beats[0].cmd;
        in_tdata <= {3'b000, work_beats[0].pri, work_beats[0].id};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: out_tready always high, random, or from a pattern; mode and pattern are redrawn on rx_cycle
  int       rx_cycle = 0;
  int       rx_mode = 0;
  logic [15:0] rx_pattern = 16'hffff;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else begin
      if (rx_cycle % 128 == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_pattern = 16'($urandom_range(0, 16'hffff));
      end
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= rx_pattern[rx_cycle % 16];
      endcase
      rx_cycle++;
    end
  end

  // track accepted work beats
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      track_work_beat(in_tuser, in_tdata[pdwq_pkg::ID_W-1:0],
                      in_tdata[pdwq_pkg::ID_W+pdwq_pkg::PRI_W-1:pdwq_pkg::ID_W]);
  end

  // check each dispatched beat against the oldest owed one
  always @(posedge clk) begin
    dispatch_t d;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_dispatch.size() == 0) begin
        $error("unexpected dispatch beat: out_id %0d last %0b",
               out_tdata[pdwq_pkg::ID_W-1:0], out_tlast);
        fail_count++;
      end else begin
        d = owed_dispatch.pop_front();
        if (out_tdata[pdwq_pkg::ID_W-1:0] !== d.id) begin
          $error("out_id mismatch: expected %0d, actual %0d", d.id,
                 out_tdata[pdwq_pkg::ID_W-1:0]);
          fail_count++;
        end
        if (out_tlast !== d.last) begin
          $error("last mismatch: expected %0b, actual %0b", d.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int n;
    int pri;
    int base;
    int k;
    for (k = 0; k < IDS; k++) pend_mark[k] = 1'b0;
    for (k = 0; k < BUCKETS; k++) list_used[k] = 1'b0;

    // directed: empty retire, range extremes, duplicates, fifo order
    add_beat(pdwq_pkg::CMD_RETIRE, 31, -1);
    add_beat(pdwq_pkg::CMD_QUEUE, 0, -128);
    add_beat(pdwq_pkg::CMD_QUEUE, 31, 127);
    add_beat(pdwq_pkg::CMD_QUEUE, 5, 0);
    add_beat(pdwq_pkg::CMD_QUEUE, 10, 7);
    add_beat(pdwq_pkg::CMD_QUEUE, 11, 8);
    add_beat(pdwq_pkg::CMD_QUEUE, 12, -1);
    add_beat(pdwq_pkg::CMD_QUEUE, 0, 3);
    add_beat(pdwq_pkg::CMD_QUEUE, 31, 127);
    add_beat(pdwq_pkg::CMD_QUEUE, 20, 3);
    add_beat(pdwq_pkg::CMD_QUEUE, 21, 3);
    add_beat(pdwq_pkg::CMD_QUEUE, 22, 3);
    add_beat(pdwq_pkg::CMD_RETIRE, 31, 127);
    add_beat(pdwq_pkg::CMD_RETIRE, 0, 0);
    add_beat(pdwq_pkg::CMD_QUEUE, 3, 1);
    add_beat(pdwq_pkg::CMD_RETIRE, 10, -128);
    add_beat(pdwq_pkg::CMD_QUEUE, 3, 1);
    add_beat(pdwq_pkg::CMD_QUEUE, 21, 85);
    add_beat(pdwq_pkg::CMD_QUEUE, 10, -86);
    add_beat(pdwq_pkg::CMD_RETIRE, 21, 85);

    // random: mostly queue beats with periodic full fills and retires
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 100 == 50) begin
        // every id queued once, then one long retire run
        base = $urandom_range(0, IDS - 1);
        for (k = 0; k < IDS; k++)
          add_beat(pdwq_pkg::CMD_QUEUE, (base + k * 7) % IDS, $urandom_range(0, 255));
        add_beat(pdwq_pkg::CMD_RETIRE, $urandom_range(0, 31), $urandom_range(0, 255));
        n += IDS + 1;
      end else if ($urandom_range(0, 9) == 0) begin
        add_beat(pdwq_pkg::CMD_RETIRE, $urandom_range(0, 31), $urandom_range(0, 255));
        n++;
      end else begin
        if ($urandom_range(0, 1) == 0) pri = $urandom_range(0, 11) - 2;
        else pri = $urandom_range(0, 255);
        add_beat(pdwq_pkg::CMD_QUEUE, $urandom_range(0, 31), pri);
        n++;
      end
    end
    add_beat(pdwq_pkg::CMD_RETIRE, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (work_beats.size() != 0) @(posedge clk);
    // let the tracker log the final beat before looking at what is owed
    @(posedge clk);
    while (owed_dispatch.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (owed_dispatch.size() != 0) begin
      $error("%0d dispatch beats never arrived", owed_dispatch.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
